// ===== src/aehd_pkg.sv =====
// shared types and constants of the archive entry header deframer
`timescale 1ns / 1ps
package aehd_pkg;

  localparam int unsigned POS_W = 33;
  localparam int unsigned SUM_W = 34;
  localparam int unsigned CNT_W = 17;
  localparam int unsigned PAY_W = 31;
  localparam int unsigned CFG_W = 32;
  localparam int unsigned IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_DATA_SIZE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_DATA_BASE   = 2'd1;
  localparam logic [IDX_W-1:0] REG_ENTRY_LIMIT = 2'd2;

  localparam logic [CNT_W-1:0] ENTRY_LIMIT_RESET = 17'd100000;
  localparam logic [7:0]       BZIP2_TAG         = 8'h31;
  localparam logic [PAY_W-1:0] LZMA_TAG          = 31'h5d;
  localparam logic [PAY_W-1:0] METHOD_WORD_BYTES = 31'd4;

  typedef enum logic [1:0] {
    PH_SIZE,
    PH_METHOD,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    EV_HALT,
    EV_EMIT,
    EV_EMIT_NOCHK
  } evt_kind_t;

  typedef enum logic [2:0] {
    ST_DATA_END,
    ST_CHECK_WORD,
    ST_BAD_HEADER,
    ST_OVERRUN,
    ST_ENTRY_LIMIT
  } stop_t;

  typedef enum logic [1:0] {
    M_STORED,
    M_BZIP2,
    M_LZMA,
    M_DEFLATE
  } method_t;

  typedef struct packed {
    logic [CFG_W-1:0] data_size;
    logic [CFG_W-1:0] data_base;
    logic [CNT_W-1:0] entry_limit;
  } cfg_t;

  // one classified header event, queued between front and back
  typedef struct packed {
    evt_kind_t        kind;
    stop_t            reason;
    logic             comp;
    method_t          meth;
    logic [PAY_W-1:0] payload;
    logic [SUM_W-1:0] start;
    logic [SUM_W-1:0] start4;
    logic [POS_W-1:0] entry_start;
    logic [CNT_W-1:0] idx;
  } evt_t;

  typedef struct packed {
    logic             entry_valid;
    logic             is_compressed;
    method_t          method;
    logic [PAY_W-1:0] payload_size;
    logic [POS_W-1:0] entry_offset;
    logic [CNT_W-1:0] entry_index;
    logic             last;
    stop_t            stop_reason;
  } res_t;

endpackage

// ===== src/aehd_front.sv =====
// byte-level header walker: assembles words and classifies entries into events
`timescale 1ns / 1ps
module aehd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             restart,
  input  aehd_pkg::cfg_t   cfg,
  input  logic             take,
  input  logic [7:0]       byte_in,
  output logic             push,
  output aehd_pkg::evt_t   evt
);
  import aehd_pkg::*;

  phase_t           phase, phase_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [1:0]       biw, biw_next;
  logic [23:0]      ws, ws_next;
  logic [PAY_W-1:0] size_hold, size_hold_next;
  logic [PAY_W-1:0] skip_left, skip_left_next;
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic [POS_W-1:0] es, es_next;
  logic [SUM_W-1:0] es4, es4_next;
  logic [SUM_W-1:0] es8, es8_next;
  logic [SUM_W-1:0] es12, es12_next;

  logic [SUM_W-1:0] p4;
  logic [SUM_W-1:0] size_ext;
  logic [31:0]      word;
  logic             do_emit;
  evt_kind_t        em_kind;
  logic             em_comp;
  method_t          em_meth;
  logic [PAY_W-1:0] em_pay;
  logic [SUM_W-1:0] em_start;
  logic [SUM_W-1:0] em_start4;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      phase       <= PH_SIZE;
      pos         <= '0;
      biw         <= '0;
      entry_count <= '0;
    end else begin
      phase       <= phase_next;
      pos         <= pos_next;
      biw         <= biw_next;
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    ws        <= ws_next;
    size_hold <= size_hold_next;
    skip_left <= skip_left_next;
    es        <= es_next;
    es4       <= es4_next;
    es8       <= es8_next;
    es12      <= es12_next;
  end

  always_comb begin
    phase_next       = phase;
    pos_next         = pos;
    biw_next         = biw;
    ws_next          = ws;
    size_hold_next   = size_hold;
    skip_left_next   = skip_left;
    entry_count_next = entry_count;
    es_next          = es;
    es4_next         = es4;
    es8_next         = es8;
    es12_next        = es12;
    p4               = {1'b0, pos} + SUM_W'(4);
    size_ext         = {2'b00, cfg.data_size};
    word             = {byte_in, ws};
    push             = 1'b0;
    evt              = '0;
    do_emit          = 1'b0;
    em_kind          = EV_EMIT;
    em_comp          = 1'b0;
    em_meth          = M_STORED;
    em_pay           = '0;
    em_start         = es4;
    em_start4        = es8;

    if (take) begin
      pos_next = pos + POS_W'(1);
      if (phase == PH_SKIP) begin
        skip_left_next = skip_left - PAY_W'(1);
        if (skip_left_next == '0) begin
          phase_next = PH_SIZE;
        end
      end else begin
        // first byte of a size word: note where the entry starts
        if (phase == PH_SIZE && biw == 2'd0) begin
          es_next   = pos;
          es4_next  = p4;
          es8_next  = {1'b0, pos} + SUM_W'(8);
          es12_next = {1'b0, pos} + SUM_W'(12);
          if (p4 >= size_ext) begin
            push       = 1'b1;
            evt.kind   = EV_HALT;
            evt.reason = ST_DATA_END;
          end
        end
        ws_next = word[31:8];
        if (biw != 2'd3) begin
          biw_next = biw + 2'd1;
        end else begin
          biw_next = 2'd0;
          if (phase == PH_SIZE) begin
            if (es8 == size_ext) begin
              push       = 1'b1;
              evt.kind   = EV_HALT;
              evt.reason = ST_CHECK_WORD;
            end else if (word[30:0] == '0) begin
              do_emit = 1'b1;
              em_kind = EV_EMIT_NOCHK;
            end else if (word[31]) begin
              if (es8 > size_ext) begin
                push       = 1'b1;
                evt.kind   = EV_HALT;
                evt.reason = ST_BAD_HEADER;
              end else begin
                size_hold_next = word[30:0];
                phase_next     = PH_METHOD;
              end
            end else begin
              do_emit = 1'b1;
              em_pay  = word[30:0];
            end
          end else begin
            if (size_hold < METHOD_WORD_BYTES) begin
              push       = 1'b1;
              evt.kind   = EV_HALT;
              evt.reason = ST_BAD_HEADER;
            end else begin
              do_emit   = 1'b1;
              em_comp   = 1'b1;
              em_pay    = size_hold - METHOD_WORD_BYTES;
              em_start  = es8;
              em_start4 = es12;
              if (word[7:0] == BZIP2_TAG) begin
                em_meth = M_BZIP2;
              end else if (word[30:0] == LZMA_TAG) begin
                em_meth = M_LZMA;
              end else begin
                em_meth = M_DEFLATE;
              end
            end
          end
        end
      end

      if (do_emit) begin
        push             = 1'b1;
        evt.kind         = em_kind;
        evt.reason       = ST_DATA_END;
        evt.comp         = em_comp;
        evt.meth         = em_meth;
        evt.payload      = em_pay;
        evt.start        = em_start;
        evt.start4       = em_start4;
        evt.entry_start  = es;
        evt.idx          = entry_count;
        entry_count_next = entry_count + CNT_W'(1);
        skip_left_next   = em_pay;
        phase_next       = (em_pay == '0) ? PH_SIZE : PH_SKIP;
      end
    end
  end

endmodule

// ===== src/aehd_fifo.sv =====
// short event queue between the front and the back
`timescale 1ns / 1ps
module aehd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           flush,
  input  logic           push,
  input  aehd_pkg::evt_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           rvalid,
  output aehd_pkg::evt_t rdata
);
  import aehd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  evt_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign rvalid  = (count != '0);
  assign rdata   = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== src/aehd_back.sv =====
// bound checks, descriptor formatting and output register
`timescale 1ns / 1ps
module aehd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           restart,
  input  aehd_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  aehd_pkg::evt_t q_evt,
  output logic           q_pop,
  output logic           res_valid,
  input  logic           res_ready,
  output aehd_pkg::res_t res
);
  import aehd_pkg::*;

  logic             a_valid;
  evt_t             a_evt;
  logic [SUM_W-1:0] a_next;
  logic [SUM_W-1:0] a_next4;
  logic [POS_W-1:0] a_off;
  logic             a_cnt_gt;
  logic             done;
  logic             out_free;
  logic             load;
  logic             a_leave;
  logic             a_ready;
  logic [SUM_W-1:0] size_ext;
  logic             chk;
  logic             over;
  logic             lim;
  logic             near;
  res_t             res_c;

  assign size_ext = {2'b00, cfg.data_size};
  assign out_free = !res_valid || res_ready;
  assign load     = a_valid && !done && out_free;
  // once parsing has ended every later event is dropped
  assign a_leave  = a_valid && (done || out_free);
  assign a_ready  = !a_valid || a_leave;
  assign q_pop    = q_valid && a_ready;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_evt    <= q_evt;
      a_next   <= q_evt.start + SUM_W'(q_evt.payload);
      a_next4  <= q_evt.start4 + SUM_W'(q_evt.payload);
      a_off    <= POS_W'(cfg.data_base) + q_evt.entry_start;
      a_cnt_gt <= (q_evt.idx + CNT_W'(1)) > cfg.entry_limit;
    end
  end

  always_comb begin
    chk   = (a_evt.kind == EV_EMIT);
    over  = chk && (a_next > size_ext);
    lim   = chk && a_cnt_gt;
    near  = (a_next4 >= size_ext);
    res_c = '0;
    if (a_evt.kind == EV_HALT) begin
      res_c.last        = 1'b1;
      res_c.stop_reason = a_evt.reason;
    end else begin
      res_c.entry_valid   = 1'b1;
      res_c.is_compressed = a_evt.comp;
      res_c.method        = a_evt.meth;
      res_c.payload_size  = a_evt.payload;
      res_c.entry_offset  = a_off;
      res_c.entry_index   = a_evt.idx;
      res_c.last          = over || lim || near;
      if (over) begin
        res_c.stop_reason = ST_OVERRUN;
      end else if (lim) begin
        res_c.stop_reason = ST_ENTRY_LIMIT;
      end else begin
        res_c.stop_reason = ST_DATA_END;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      res_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        done      <= res_c.last;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_c;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res.last |=> !res_valid)
    else $error("result after the final item");
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.entry_valid || res.last))
    else $error("empty result that does not end parsing");
  assert property (@(posedge clk) disable iff (rst)
    done |-> !load)
    else $error("event loaded after parsing ended");
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |-> res.stop_reason == ST_DATA_END)
    else $error("stop reason on a non-final result");
`endif

endmodule

// ===== src/archive_entry_header_deframer.sv =====
// top level of the archive entry header deframer
// path: the event of an accepted header byte passes the event queue, the check stage and
// the output register before its result shows; the result side can stall it on the way
// throughput: one data byte per cycle while the event queue has room, set by the byte walker
// in the front; reset: synchronous, clears parse state, queue and output; config registers take
// their reset values (entry limit 100000); a write to a known register restarts parsing from byte zero
`timescale 1ns / 1ps
module archive_entry_header_deframer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  // data byte channel
  input  logic                        data_valid,
  output logic                        data_ready,
  input  logic [7:0]                  data_byte,
  // result channel
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic                        entry_valid,
  output logic                        is_compressed,
  output logic [1:0]                  method,
  output logic [aehd_pkg::PAY_W-1:0]  payload_size,
  output logic [aehd_pkg::POS_W-1:0]  entry_offset,
  output logic [aehd_pkg::CNT_W-1:0]  entry_index,
  output logic                        last,
  output logic [2:0]                  stop_reason,
  // configuration writes
  input  logic                        cfg_we,
  input  logic [aehd_pkg::IDX_W-1:0]  cfg_index,
  input  logic [aehd_pkg::CFG_W-1:0]  cfg_data
);
  import aehd_pkg::*;

  cfg_t cfg;
  logic restart;
  logic take;
  logic push;
  evt_t push_evt;
  logic q_full;
  logic q_valid;
  evt_t q_evt;
  logic q_pop;
  res_t res;

  // a write to a known register restarts the walk; unknown indexes are ignored
  assign restart = cfg_we && (cfg_index == REG_DATA_SIZE || cfg_index == REG_DATA_BASE ||
                              cfg_index == REG_ENTRY_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.data_size   <= '0;
      cfg.data_base   <= '0;
      cfg.entry_limit <= ENTRY_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DATA_SIZE:   cfg.data_size   <= cfg_data;
        REG_DATA_BASE:   cfg.data_base   <= cfg_data;
        REG_ENTRY_LIMIT: cfg.entry_limit <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // the front takes a byte whenever the queue has room for a possible event
  assign data_ready = !q_full;
  assign take       = data_valid && data_ready;

  aehd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .cfg     (cfg),
    .take    (take),
    .byte_in (data_byte),
    .push    (push),
    .evt     (push_evt)
  );

  // events wait here so the byte side keeps moving while results stall
  aehd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .flush  (restart),
    .push   (push),
    .wdata  (push_evt),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_evt)
  );

  // overrun, limit and end checks, then the output register
  aehd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_evt     (q_evt),
    .q_pop     (q_pop),
    .res_valid (result_valid),
    .res_ready (result_ready),
    .res       (res)
  );

  assign entry_valid   = res.entry_valid;
  assign is_compressed = res.is_compressed;
  assign method        = res.method;
  assign payload_size  = res.payload_size;
  assign entry_offset  = res.entry_offset;
  assign entry_index   = res.entry_index;
  assign last          = res.last;
  assign stop_reason   = res.stop_reason;

endmodule
